// File: hw/rtl/assert_macros.svh
// assertion macros used by the core rtl file
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

// File: hw/rtl/wlpc_pkg.sv
// types and constants of the wear leveled persistent counter
// no dependencies
package wlpc_pkg;

  // request codes on req_type
  localparam logic [1:0] REQ_INC     = 2'd0;
  localparam logic [1:0] REQ_RECOVER = 2'd1;
  localparam logic [1:0] REQ_PRELOAD = 2'd2;

  // result kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // slot content that marks a slot invalid
  localparam logic [31:0] INVALID_MARK = 32'hFFFF_FFFF;
  // low sub-counter bits that must be zero for a slot rewrite
  localparam logic [7:0]  REWRITE_MASK = 8'h0F;
  localparam logic [7:0]  ERASED_BYTE  = 8'hFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_CMP,
    ST_SCAN,
    ST_SCAN_END,
    ST_STATUS
  } state_t;

endpackage

// File: hw/rtl/wlpc_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module wlpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/wear_leveled_persistent_counter_core.sv
// top level of the wear leveled persistent counter
// depends on wlpc_pkg, wlpc_ram and assert_macros.svh
//
// A 32-bit event counter kept in a ring of SLOTS four-byte slots of an
// emulated eeprom (byte ram, msb first per slot, 0xFFFFFFFF = invalid slot).
// A request is taken at a clock edge with start high and busy low. Every
// result word leaves on the result ports for exactly one cycle with strobe
// high; the receiver cannot stall it, so it must take every strobe. Byte
// write words (kind 0) come first in write order, then one status word
// (kind 1, last high) closes each request.
// Sequencing, set by the byte ram and its registered read port:
//   - after reset a clearing pass erases the store, busy stays high
//     until all SLOTS*4 bytes are erased
//   - increment with no rewrite, preload or unknown request: status, then idle
//   - a slot rewrite reads each byte, then compares it and writes it if it
//     changed, for one slot, or for the every-256th invalidate plus move
//     to the next slot
//   - recover streams every store byte through the ram read port, and
//     when no slot is valid, slot 0 is then written with zero
// The status word of a request appears in the first cycle with busy low,
// so a new request may be issued in that same cycle.
// store_base is written with store_base_we; write it only while idle.
module wear_leveled_persistent_counter_core
  import wlpc_pkg::*;
#(
  parameter int SLOTS = 128
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        store_base_we,
  input  logic [15:0] store_base_wdata,
  // request side
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [8:0]  load_offset,
  input  logic [7:0]  load_byte,
  // result side
  output logic        strobe,
  output logic        kind,
  output logic [15:0] store_addr,
  output logic [7:0]  store_byte,
  output logic [31:0] counter_value,
  output logic [6:0]  slot_index,
  output logic        last
);

  localparam int STORE_BYTES = SLOTS * 4;
  localparam int SW = $clog2(SLOTS);
  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = $clog2(STORE_BYTES + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [CW-1:0] SCAN_END_CNT = CW'(STORE_BYTES);

  // control state
  state_t         state, state_next;
  logic [31:0]    count_now;
  logic [SW-1:0]  slot_now;
  logic [7:0]     sub_count;
  logic [15:0]    store_base;
  logic [AW-1:0]  clear_addr;

  // slot write sequencer
  logic [SW-1:0]  wr_slot;
  logic [31:0]    wr_value;
  logic [1:0]     wr_byte;
  logic           second_pending;   // move to the next slot after this one

  // recovery scan
  logic [CW-1:0]  scan_addr;
  logic           scan_vld;         // read data of scan_raddr arrives now
  logic [AW-1:0]  scan_raddr;
  logic [23:0]    scan_word;
  logic           found;
  logic [31:0]    best;
  logic [SW-1:0]  best_slot;

  // byte ram
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     rd_data;

  // result word before the output register
  logic           res_strobe;
  logic           res_kind;
  logic [15:0]    res_addr;
  logic [7:0]     res_byte;
  logic [31:0]    res_count;
  logic [6:0]     res_slot;
  logic           res_last;

  // helpers
  logic           accept;
  logic [7:0]     inc_sub;
  logic           inc_wrap;
  logic           inc_rewrite;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     new_byte;
  logic [SW-1:0]  slot_after;
  logic           load_in_range;
  logic [31:0]    scan_value;
  logic           scan_issue;
  logic           scan_better;

  wlpc_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign busy          = (state != ST_IDLE);
  assign accept        = start && !busy;
  assign inc_sub       = sub_count + 8'd1;
  assign inc_wrap      = (inc_sub == 8'd0);
  assign inc_rewrite   = ((inc_sub & REWRITE_MASK) == 8'd0);
  assign wr_addr       = {wr_slot, wr_byte};
  // msb first: byte 0 of a slot is bits 31:24
  assign new_byte      = 8'(wr_value >> {2'd3 - wr_byte, 3'b000});
  assign slot_after    = (wr_slot == LAST_SLOT) ? '0 : wr_slot + SW'(1);
  assign load_in_range = (32'(load_offset) < 32'(STORE_BYTES));
  assign scan_value    = {scan_word, rd_data};
  assign scan_issue    = (scan_addr != SCAN_END_CNT);
  // lowest slot wins a tie, so only a strictly larger value replaces best
  assign scan_better   = (scan_raddr[1:0] == 2'd3) && (scan_value != INVALID_MARK) &&
                         (!found || (scan_value > best));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_INC:     state_next = inc_rewrite ? ST_WR_RD : ST_STATUS;
            REQ_RECOVER: state_next = ST_SCAN;
            default:     state_next = ST_STATUS;
          endcase
        end
      end
      ST_WR_RD:  state_next = ST_WR_CMP;
      ST_WR_CMP: begin
        if (wr_byte == 2'd3 && !second_pending) begin
          state_next = ST_STATUS;
        end else begin
          state_next = ST_WR_RD;
        end
      end
      ST_SCAN: begin
        if (scan_vld && scan_raddr == LAST_ADDR) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_next = found ? ST_STATUS : ST_WR_RD;
      ST_STATUS:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // ram controls and result word
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = clear_addr;
    mem_wdata  = ERASED_BYTE;
    mem_raddr  = wr_addr;
    res_strobe = 1'b0;
    res_kind   = KIND_WRITE;
    res_addr   = 16'd0;
    res_byte   = 8'd0;
    res_count  = 32'd0;
    res_slot   = 7'd0;
    res_last   = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        if (start && req_type == REQ_PRELOAD && load_in_range) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(load_offset);
          mem_wdata = load_byte;
        end
      end
      ST_WR_CMP: begin
        // only bytes that change are written and reported
        if (rd_data != new_byte) begin
          mem_we     = 1'b1;
          mem_waddr  = wr_addr;
          mem_wdata  = new_byte;
          res_strobe = 1'b1;
          res_addr   = store_base + 16'(wr_addr);
          res_byte   = new_byte;
        end
      end
      ST_SCAN: begin
        mem_raddr = scan_addr[AW-1:0];
      end
      ST_STATUS: begin
        res_strobe = 1'b1;
        res_kind   = KIND_STATUS;
        res_count  = count_now;
        res_slot   = 7'(slot_now);
        res_last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      count_now  <= 32'd0;
      slot_now   <= '0;
      sub_count  <= 8'd0;
      store_base <= 16'd0;
      strobe     <= 1'b0;
      scan_vld   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= res_strobe;
      if (store_base_we) begin
        store_base <= store_base_wdata;
      end
      case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            wr_slot        <= slot_now;
            wr_byte        <= 2'd0;
            second_pending <= 1'b0;
            case (req_type)
              REQ_INC: begin
                count_now      <= count_now + 32'd1;
                sub_count      <= inc_sub;
                // every 256th: invalidate this slot first, then move on
                wr_value       <= inc_wrap ? INVALID_MARK : count_now + 32'd1;
                second_pending <= inc_wrap;
              end
              REQ_RECOVER: begin
                sub_count <= 8'd0;
                scan_addr <= '0;
                scan_vld  <= 1'b0;
                found     <= 1'b0;
                best      <= 32'd0;
                best_slot <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_WR_CMP: begin
          wr_byte <= wr_byte + 2'd1;
          if (wr_byte == 2'd3 && second_pending) begin
            second_pending <= 1'b0;
            wr_slot        <= slot_after;
            wr_value       <= count_now;
            slot_now       <= slot_after;
          end
        end
        ST_SCAN: begin
          // one byte read per cycle, data arrives through the registered read port
          scan_vld   <= scan_issue;
          scan_raddr <= scan_addr[AW-1:0];
          if (scan_issue) begin
            scan_addr <= scan_addr + CW'(1);
          end
          if (scan_vld) begin
            scan_word <= {scan_word[15:0], rd_data};
            if (scan_better) begin
              found     <= 1'b1;
              best      <= scan_value;
              best_slot <= scan_raddr[AW-1:2];
            end
          end
        end
        ST_SCAN_END: begin
          if (found) begin
            count_now <= best;
            slot_now  <= best_slot;
          end else begin
            // nothing valid: restart at zero in slot 0
            count_now      <= 32'd0;
            slot_now       <= '0;
            wr_slot        <= '0;
            wr_value       <= 32'd0;
            wr_byte        <= 2'd0;
            second_pending <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register, payload needs no reset
  always_ff @(posedge clk) begin
    kind          <= res_kind;
    store_addr    <= res_addr;
    store_byte    <= res_byte;
    counter_value <= res_count;
    slot_index    <= res_slot;
    last          <= res_last;
  end

`include "assert_macros.svh"

  // a byte written by the slot sequencer is always reported next cycle
  `ASSERT_CLK(a_write_reported, clk, rst, (mem_we && state == ST_WR_CMP) |=> (strobe && kind == KIND_WRITE))
  // a request stays busy until its closing status word
  `ASSERT_CLK(a_busy_until_last, clk, rst, (strobe && !last) |-> busy)
  // an accepted request always leaves idle
  `ASSERT_CLK(a_accept_leaves_idle, clk, rst, accept |=> (state != ST_IDLE))
  // the status state produces the closing word
  `ASSERT_CLK(a_status_closes, clk, rst, (state == ST_STATUS) |=> (strobe && last && kind == KIND_STATUS))
  // the current slot stays inside the ring
  `ASSERT_NEVER(a_slot_in_ring, clk, rst, 32'(slot_now) >= 32'(SLOTS))

endmodule

// File: tb/sv/wear_leveled_persistent_counter_core_test.sv
// self-checking testbench for the wear leveled persistent counter core
// depends on wlpc_pkg and wear_leveled_persistent_counter_core; checks every result word
// against a cycle-free predictor of the slot ring, byte image and counters
module wear_leveled_persistent_counter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wlpc_pkg::*;

  localparam int RING_SLOTS = 128;
  localparam int STORE_SIZE = RING_SLOTS * 4;
  // request code the block does not know, answered with a bare status word
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  // slowest correct run is the clearing pass, every recover scan and all the
  // increment, preload and unknown-code requests with their random sender gaps;
  // this limit lies well above the length of such a run
  localparam int CYCLE_LIMIT = 200000;
  // a recover with slot 0 rewrite is the longest request
  localparam int DRAIN_LIMIT = 2000;
  // quiet cycles after the last expected word before touching the register
  localparam int SETTLE_CYCLES = 24;

  // one result word as the block presents it
  typedef struct packed {
    logic        kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [31:0] count;
    logic [6:0]  slot;
    logic        last;
  } store_word_t;

  logic clk = 1'b0;
  logic rst;
  logic store_base_we;
  logic [15:0] store_base_wdata;
  logic start;
  logic busy;
  logic [1:0] req_type;
  logic [8:0] load_offset;
  logic [7:0] load_byte;
  logic strobe;
  logic kind;
  logic [15:0] store_addr;
  logic [7:0] store_byte;
  logic [31:0] counter_value;
  logic [6:0] slot_index;
  logic last;

  wear_leveled_persistent_counter_core #(
    .SLOTS(RING_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .store_base_we(store_base_we),
    .store_base_wdata(store_base_wdata),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .load_offset(load_offset),
    .load_byte(load_byte),
    .strobe(strobe),
    .kind(kind),
    .store_addr(store_addr),
    .store_byte(store_byte),
    .counter_value(counter_value),
    .slot_index(slot_index),
    .last(last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: the eeprom image, counter, current slot, sub-counter
  // and the base address register as the block should hold them
  logic [7:0]  eeprom_img [STORE_SIZE];
  logic [31:0] count_mdl;
  logic [6:0]  slot_mdl;
  logic [7:0]  sub_mdl;
  logic [15:0] base_mdl;

  // words the block still owes us, oldest first
  store_word_t pending_words[$];

  int error_count = 0;
  int words_checked = 0;
  int items_sent = 0;
  int recover_count = 0;
  int slot_moves = 0;
  int cycle_count = 0;
  // when set the sender issues back to back with no idle cycles
  bit steady_sender = 1'b0;

  function automatic logic [8:0] rnd_offset();
    return 9'($urandom_range(0, STORE_SIZE - 1));
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // slot contents, msb first
  function automatic logic [31:0] slot_value(input int s);
    return {eeprom_img[s*4], eeprom_img[s*4+1], eeprom_img[s*4+2], eeprom_img[s*4+3]};
  endfunction

  // store a value into a slot, one write word per byte that actually changes
  task automatic put_slot(input int s, input logic [31:0] value);
    store_word_t w;
    logic [7:0] nb;
    int a;
    for (int i = 0; i < 4; i++) begin
      a = s * 4 + i;
      nb = value[31-8*i -: 8];
      if (eeprom_img[a] !== nb) begin
        eeprom_img[a] = nb;
        w = '0;
        w.kind = KIND_WRITE;
        w.addr = base_mdl + a[15:0];
        w.data = nb;
        pending_words.push_back(w);
      end
    end
  endtask

  // advance the predictor by one accepted request and queue its words
  task automatic model_request(input logic [1:0] req, input logic [8:0] off,
                               input logic [7:0] lb);
    store_word_t w;
    logic [31:0] best;
    logic [31:0] v;
    int best_slot;
    bit found;
    case (req)
      REQ_INC: begin
        count_mdl = count_mdl + 1;
        sub_mdl = sub_mdl + 1;
        if (sub_mdl == 8'd0) begin
          // every 256th: retire the slot, then move to the next one
          put_slot(slot_mdl, INVALID_MARK);
          slot_mdl = slot_mdl + 1;
          put_slot(slot_mdl, count_mdl);
          slot_moves++;
        end else if ((sub_mdl & REWRITE_MASK) == 8'd0) begin
          put_slot(slot_mdl, count_mdl);
        end
      end
      REQ_RECOVER: begin
        found = 1'b0;
        best = '0;
        best_slot = 0;
        // highest valid value wins, lowest slot on a tie
        for (int s = 0; s < RING_SLOTS; s++) begin
          v = slot_value(s);
          if (v != INVALID_MARK && (!found || v > best)) begin
            best = v;
            best_slot = s;
            found = 1'b1;
          end
        end
        if (found) begin
          count_mdl = best;
          slot_mdl = best_slot[6:0];
        end else begin
          // empty ring: restart from zero in slot 0
          count_mdl = '0;
          slot_mdl = '0;
          put_slot(0, 32'd0);
        end
        sub_mdl = '0;
        recover_count++;
      end
      REQ_PRELOAD: begin
        eeprom_img[off] = lb;
      end
      default: begin
      end
    endcase
    w = '0;
    w.kind = KIND_STATUS;
    w.count = count_mdl;
    w.slot = slot_mdl;
    w.last = 1'b1;
    pending_words.push_back(w);
  endtask

  // present one request after a random idle gap, or none for a steady sender, and hold it until taken
  task automatic send_request(input logic [1:0] req, input logic [8:0] off,
                              input logic [7:0] lb);
    int gap;
    gap = steady_sender ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= req;
    load_offset <= off;
    load_byte <= lb;
    do @(posedge clk); while (busy !== 1'b0);
    model_request(req, off, lb);
    items_sent++;
  endtask

  // stop sending and wait for every owed word, then let the block settle
  task automatic wait_drained();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_words.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected words never arrived", $time, pending_words.size());
      pending_words.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // base register write, only with the block idle
  task automatic write_base(input logic [15:0] value);
    while (busy !== 1'b0) @(posedge clk);
    store_base_we <= 1'b1;
    store_base_wdata <= value;
    @(posedge clk);
    store_base_we <= 1'b0;
    base_mdl = value;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // result side: the block cannot be stalled, so every strobe is a word
  always @(posedge clk) begin : check_words
    store_word_t w;
    if (!rst && strobe === 1'b1) begin
      if (pending_words.size() == 0) begin
        error_count++;
        $display("%0t: word with nothing expected, expected none actual kind %0d addr %h count %h",
                 $time, kind, store_addr, counter_value);
      end else begin
        w = pending_words.pop_front();
        words_checked++;
        check_field("kind", w.kind, kind);
        check_field("store_addr", w.addr, store_addr);
        check_field("store_byte", w.data, store_byte);
        check_field("counter_value", w.count, counter_value);
        check_field("slot_index", w.slot, slot_index);
        check_field("last", w.last, last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // hand-picked requests: empty ring, unknown code, extremes of the
  // offset and byte fields, top slot, counter rolling through zero
  task automatic test_directed();
    write_base(16'hFFFF);
    // nothing valid after the clearing pass: slot 0 zeroed, addresses wrap
    send_request(REQ_RECOVER, rnd_offset(), rnd_byte());
    send_request(REQ_UNKNOWN, rnd_offset(), rnd_byte());
    // slots 5 and 9 get the same large value, slot 0 a smaller one, so the scan sees a tie
    send_request(REQ_PRELOAD, 9'd23, 8'h10);
    send_request(REQ_PRELOAD, 9'd39, 8'h10);
    send_request(REQ_PRELOAD, 9'd0, 8'hFF);
    send_request(REQ_PRELOAD, 9'd1, 8'h00);
    send_request(REQ_RECOVER, rnd_offset(), rnd_byte());
    // last byte of the store lifts slot 127 to the top
    send_request(REQ_PRELOAD, 9'd511, 8'hF0);
    send_request(REQ_RECOVER, rnd_offset(), rnd_byte());
    // 16 increments roll the counter through zero and rewrite slot 127
    repeat (16) send_request(REQ_INC, rnd_offset(), rnd_byte());
    wait_drained();
  endtask

  // long increment runs with some preload and unknown-code noise, at least one slot move
  task automatic test_increment_runs();
    int n;
    int r;
    int moves0;
    write_base(16'($urandom_range(0, 65535)));
    moves0 = slot_moves;
    n = 0;
    while (n < 230 || slot_moves == moves0) begin
      if (n % 32 == 0)
        steady_sender = ($urandom_range(0, 3) == 0);
      // sender holds off once until the block has answered everything
      if (n == 120)
        wait_drained();
      r = $urandom_range(0, 99);
      if (r < 93) begin
        send_request(REQ_INC, rnd_offset(), rnd_byte());
      end else if (r < 95) begin
        // disturb the current slot so the next rewrite touches other bytes
        send_request(REQ_PRELOAD, {slot_mdl, 2'($urandom_range(0, 3))}, rnd_byte());
      end else if (r < 98) begin
        send_request(REQ_PRELOAD, rnd_offset(), rnd_byte());
      end else begin
        send_request(REQ_UNKNOWN, rnd_offset(), rnd_byte());
      end
      n++;
    end
    steady_sender = 1'b0;
    wait_drained();
  endtask

  // doctored rings followed by a recover scan and a few increments
  task automatic test_recover_sequences();
    int s;
    int extra;
    logic [31:0] v;
    write_base(16'h0000);
    for (int q = 0; q < 6; q++) begin
      if (q == 3) begin
        wait_drained();
        write_base(16'($urandom_range(0, 65535)));
      end
      if (q % 2 == 0) begin
        // copy the current slot into one at or below it so the scan may see a tie
        s = $urandom_range(0, slot_mdl);
        v = slot_value(slot_mdl);
        for (int i = 0; i < 4; i++)
          send_request(REQ_PRELOAD, 9'(s * 4 + i), v[31-8*i -: 8]);
      end else begin
        // random damage, often erasing bytes
        repeat ($urandom_range(1, 3))
          send_request(REQ_PRELOAD, rnd_offset(),
                       ($urandom_range(0, 3) == 0) ? ERASED_BYTE : rnd_byte());
      end
      if ($urandom_range(0, 2) == 0)
        send_request(REQ_UNKNOWN, rnd_offset(), rnd_byte());
      send_request(REQ_RECOVER, rnd_offset(), rnd_byte());
      // the last round runs past the first rewrite after the scan
      extra = (q == 5) ? 17 : $urandom_range(0, 5);
      repeat (extra) send_request(REQ_INC, rnd_offset(), rnd_byte());
    end
    wait_drained();
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    store_base_we <= 1'b0;
    store_base_wdata <= '0;
    req_type <= REQ_INC;
    load_offset <= '0;
    load_byte <= '0;
    // predictor starts from an erased store
    for (int i = 0; i < STORE_SIZE; i++)
      eeprom_img[i] = ERASED_BYTE;
    count_mdl = '0;
    slot_mdl = '0;
    sub_mdl = '0;
    base_mdl = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_increment_runs();
    test_recover_sequences();

    $display("covered %0d requests: %0d recover scans, %0d slot moves, %0d words checked",
             items_sent, recover_count, slot_moves, words_checked);
    $display("base address at 0x0000, 0xFFFF and random values, with and without sender gaps");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/wlpc_pkg.sv
hw/rtl/wlpc_ram.sv
hw/rtl/wear_leveled_persistent_counter_core.sv
tb/sv/wear_leveled_persistent_counter_core_test.sv
